[src/sts_pkg.sv]
// Shared types and constants for the save-type signature scanner.
// Holds the signature text and length tables and the result kind codes.
// No dependencies.
package sts_pkg;

   localparam int SIG_COUNT  = 5;
   localparam int SIG_MAXLEN = 10;
   localparam int POS_W      = 4;
   localparam int KIND_W     = 3;
   localparam int WORD_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int WORD_BYTES = WORD_W / BYTE_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE     = 3'd0,
      KIND_EEPROM   = 3'd1,
      KIND_SRAM     = 3'd2,
      KIND_FLASH    = 3'd3,
      KIND_FLASH512 = 3'd4,
      KIND_FLASH1M  = 3'd5
   } kind_type;

   typedef logic [SIG_COUNT-1:0][POS_W-1:0] pos_array_type;

   localparam logic [BYTE_W-1:0] SIG_TEXT [SIG_COUNT][SIG_MAXLEN] = '{
      '{"E", "E", "P", "R", "O", "M", "_", "V", 8'h00, 8'h00},
      '{"S", "R", "A", "M", "_", "V", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"F", "L", "A", "S", "H", "_", "V", 8'h00, 8'h00, 8'h00},
      '{"F", "L", "A", "S", "H", "5", "1", "2", "_", "V"},
      '{"F", "L", "A", "S", "H", "1", "M", "_", "V", 8'h00}
   };

   localparam logic [POS_W-1:0] SIG_LEN [SIG_COUNT] = '{
      4'd8, 4'd6, 4'd7, 4'd10, 4'd9
   };

endpackage

[src/sts_word_scan.sv]
// One-word matcher: runs four bytes, lowest first, through the five signature trackers.
// Returns the updated match positions and the kind of the first completed signature.
// Depends on sts_pkg.
module sts_word_scan (
   input  logic [sts_pkg::WORD_W-1:0] word,
   input  sts_pkg::pos_array_type     pos_cur,
   output sts_pkg::pos_array_type     pos_nxt,
   output sts_pkg::kind_type          kind
);
   import sts_pkg::*;

   always_comb begin
      logic [POS_W-1:0]  p;
      logic [BYTE_W-1:0] b;
      pos_nxt = pos_cur;
      kind    = KIND_NONE;
      for (int i = 0; i < WORD_BYTES; i++) begin
         b = word[BYTE_W*i +: BYTE_W];
         for (int k = 0; k < SIG_COUNT; k++) begin
            // stop at the first completion: later trackers and bytes are skipped
            if (kind == KIND_NONE) begin
               p = pos_nxt[k];
               if (p >= SIG_LEN[k]) begin
                  p = '0;
               end
               if (b == SIG_TEXT[k][p]) begin
                  p = p + 1'b1;
                  pos_nxt[k] = p;
                  if (p == SIG_LEN[k]) begin
                     kind = kind_type'(KIND_W'(k + 1));
                  end
               end else begin
                  pos_nxt[k] = '0;
               end
            end
         end
      end
   end

endmodule

[src/save_type_signature_scanner_core.sv]
// Top level of the save-type signature scanner: input register, word matcher,
// scan state and result register. Depends on sts_pkg and sts_word_scan.
//
//   channel | ports                                   | direction
//   req     | req_valid, req_stall, req_rom_word,      | in (stall out)
//           | req_last_word                            |
//   rsp     | rsp_valid, rsp_stall, rsp_backup_kind    | out (stall in)
//
// One word per cycle while req_stall is low; a word waits in the input register, then its match result is registered.
// The per-word match is combinational, between the input and result registers.
// Synchronous reset clears match positions, the found flag and both valid bits.
// A word in the input register holds while a result waits and rsp_stall is high.
module save_type_signature_scanner_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sts_pkg::WORD_W-1:0]    req_rom_word,
   input  logic                          req_last_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sts_pkg::KIND_W-1:0]    rsp_backup_kind
);
   import sts_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_word_ff,  s1_word_in;
   logic              s1_last_ff,  s1_last_in;
   pos_array_type     pos_ff,      pos_in;
   logic              done_ff,     done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff,  rsp_kind_in;

   pos_array_type     pos_scan;
   kind_type          kind_scan;
   logic              out_free;
   logic              advance;
   logic              req_xfer;

   sts_word_scan u_scan (
      .word    (s1_word_ff),
      .pos_cur (pos_ff),
      .pos_nxt (pos_scan),
      .kind    (kind_scan)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      s1_last_in  = s1_last_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_word_in  = req_rom_word;
         s1_last_in  = req_last_word;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      pos_in       = pos_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      if (advance) begin
         if (!done_ff) begin
            pos_in = pos_scan;
            if (kind_scan != KIND_NONE) begin
               done_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_scan;
            end else if (s1_last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_NONE;
            end
         end
         if (s1_last_ff) begin
            pos_in  = '0;
            done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      s1_last_ff  <= s1_last_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_backup_kind = rsp_kind_ff;

endmodule
